// File: src/als_pkg.sv
// Shared types, codes and helpers for the addressable LED serializer.
package als_pkg;

    typedef enum logic [1:0] {
        CMD_SET_PIXEL = 2'd0,
        CMD_CLEAR     = 2'd1,
        CMD_SHOW      = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [2:0] REG_ONE_LOW   = 3'd3;
    localparam logic [2:0] REG_LATCH_GAP = 3'd4;

    localparam logic [7:0]  ZERO_HIGH_RESET = 8'd4;
    localparam logic [7:0]  ZERO_LOW_RESET  = 8'd8;
    localparam logic [7:0]  ONE_HIGH_RESET  = 8'd10;
    localparam logic [7:0]  ONE_LOW_RESET   = 8'd3;
    localparam logic [15:0] LATCH_GAP_RESET = 16'd1000;

    localparam int PIXEL_W = 24;
    localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [15:0] latch_gap;
    } timing_t;

    // Fields from the lowest bit up: data_line, busy_res, rejected.
    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic data_line;
    } result_t;

    // A programmed duration of zero behaves as one tick.
    function automatic logic [15:0] at_least_one(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

// File: src/als_pixel_store.sv
// Pixel memory with per-entry valid bits, a pixel 0 copy and a registered read port.
module als_pixel_store #(
    parameter int LED_COUNT = 64,
    parameter int AW        = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  als_pkg::pixel_t       wr_data,
    input  logic                  clr,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output als_pkg::pixel_t       rd_pixel,
    output als_pkg::pixel_t       pix0
);

    als_pkg::pixel_t mem [LED_COUNT];
    als_pkg::pixel_t rd_data_reg;
    logic            rd_vld_reg;
    logic [LED_COUNT-1:0] vld_reg;
    als_pkg::pixel_t pix0_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset or the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            pix0_reg   <= '0;
        end
        else
        begin
            if (clr)
            begin
                vld_reg  <= '0;
                pix0_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
                if (wr_addr == '0)
                begin
                    pix0_reg <= wr_data;
                end
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_pixel = rd_vld_reg ? rd_data_reg : '0;
    assign pix0     = pix0_reg;

endmodule

// File: src/als_serializer.sv
// Bit timing sequencer: phase, tick counter, shift register and pixel pointer.
module als_serializer #(
    parameter int LED_COUNT = 64,
    parameter int AW        = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  als_pkg::cmd_t     cmd,
    input  als_pkg::timing_t  timing,
    input  als_pkg::pixel_t   pix0,
    input  als_pkg::pixel_t   next_pix,
    output logic              idle,
    output als_pkg::result_t  res,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr
);

    localparam int CW = $clog2(LED_COUNT + 2);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    phase_t          phase_reg, phase_next;
    als_pkg::pixel_t shift_reg, shift_next;
    logic [4:0]      bit_cnt_reg, bit_cnt_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [15:0]     tick_cnt_reg, tick_cnt_next;
    logic            line_reg, line_next;
    logic            rej;
    logic            start_high;
    logic [15:0]     tick_dec;
    logic [4:0]      bit_inc;
    logic [CW-1:0]   ptr_inc;
    logic [CW-1:0]   ptr_inc2;

    assign tick_dec = tick_cnt_reg - 16'd1;
    assign bit_inc  = bit_cnt_reg + 5'd1;
    assign ptr_inc  = CW'(ptr_reg) + CW'(1);
    assign ptr_inc2 = CW'(ptr_reg) + CW'(2);

    always_comb
    begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        bit_cnt_next  = bit_cnt_reg;
        ptr_next      = ptr_reg;
        tick_cnt_next = tick_cnt_reg;
        line_next     = line_reg;
        rej           = 1'b0;
        start_high    = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = ptr_inc2[AW-1:0];
        if (step)
        begin
            if (cmd == als_pkg::CMD_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_cnt_next = tick_dec;
                    if (tick_dec == 16'd0)
                    begin
                        case (phase_reg)
                            PH_HIGH:
                            begin
                                phase_next    = PH_LOW;
                                line_next     = 1'b0;
                                tick_cnt_next = als_pkg::at_least_one(16'(shift_reg[23] ?
                                                timing.one_low : timing.zero_low));
                            end
                            PH_LOW:
                            begin
                                if (bit_inc >= als_pkg::BITS_PER_PIXEL)
                                begin
                                    bit_cnt_next = 5'd0;
                                    if (ptr_inc >= CW'(LED_COUNT))
                                    begin
                                        ptr_next      = '0;
                                        phase_next    = PH_GAP;
                                        line_next     = 1'b0;
                                        tick_cnt_next =
                                            als_pkg::at_least_one(timing.latch_gap);
                                    end
                                    else
                                    begin
                                        // The next pixel was fetched while this one was sent.
                                        ptr_next   = ptr_inc[AW-1:0];
                                        shift_next = next_pix;
                                        start_high = 1'b1;
                                        rd_en      = (ptr_inc2 < CW'(LED_COUNT));
                                    end
                                end
                                else
                                begin
                                    bit_cnt_next = bit_inc;
                                    shift_next   = {shift_reg[22:0], 1'b0};
                                    start_high   = 1'b1;
                                end
                            end
                            PH_GAP:
                            begin
                                phase_next    = PH_IDLE;
                                line_next     = 1'b0;
                                tick_cnt_next = 16'd0;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else if (cmd == als_pkg::CMD_SHOW)
            begin
                ptr_next     = '0;
                bit_cnt_next = 5'd0;
                shift_next   = pix0;
                start_high   = 1'b1;
                rd_en        = (LED_COUNT > 1);
                rd_addr      = AW'(1);
            end
        end
        if (start_high)
        begin
            phase_next    = PH_HIGH;
            line_next     = 1'b1;
            tick_cnt_next = als_pkg::at_least_one(16'(shift_next[23] ?
                            timing.one_high : timing.zero_high));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            shift_reg    <= '0;
            bit_cnt_reg  <= 5'd0;
            ptr_reg      <= '0;
            tick_cnt_reg <= 16'd0;
            line_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            bit_cnt_reg  <= bit_cnt_next;
            ptr_reg      <= ptr_next;
            tick_cnt_reg <= tick_cnt_next;
            line_reg     <= line_next;
        end
    end

    assign idle          = (phase_reg == PH_IDLE);
    assign res.data_line = line_next;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.rejected  = rej;

endmodule

// File: src/addressable_led_serializer.sv
// Top level of the addressable LED serializer: stream ports, timing registers, output stage.
//
// Input beats carry a command in s_tuser and pixel data in s_tdata. Every accepted
// beat, tick or not, gives exactly one output beat with the line level, busy and
// rejected flags. The result of a beat is loaded into the output register when
// it is accepted, and a new beat is taken every cycle while the output side keeps up:
// set_pixel, clear, show and tick are each handled by their own beat. During a frame the
// next pixel is read from the pixel memory in the background after each pixel starts,
// so pixel boundaries never stall the input; pixel 0 is kept in a register of its own.
// When m_tready is low the finished result waits in the output register and s_tready
// drops until it is taken. Reset clears the pixel store (through valid bits, with no
// sweep), returns the line low and idle, and loads the default timing registers.
// Timing registers are written over the cfg channel, which is always ready; writes to
// indexes beyond the last register are ignored. Set_pixel, clear and show arriving
// during a frame or the latch gap are dropped and flagged as rejected.
module addressable_led_serializer #(
    parameter int LED_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_index, red, green, blue
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // data_line, busy_res, rejected, zero padding
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    als_pkg::timing_t timing_reg;
    logic             m_tvalid_reg;
    als_pkg::result_t m_res_reg;
    logic             accept;
    als_pkg::cmd_t    cmd;
    logic             idle;
    logic             in_range;
    logic             wr_en;
    logic             clr;
    als_pkg::pixel_t  pix0;
    als_pkg::pixel_t  next_pix;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    als_pkg::result_t res;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = als_pkg::cmd_t'(s_tuser);
    assign in_range  = ({1'b0, s_tdata[7:0]} < 9'(LED_COUNT));
    assign wr_en     = accept && idle && (cmd == als_pkg::CMD_SET_PIXEL) && in_range;
    assign clr       = accept && idle && (cmd == als_pkg::CMD_CLEAR);
    assign cfg_ready = 1'b1;

    als_pixel_store #(
        .LED_COUNT (LED_COUNT),
        .AW        (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (s_tdata[AW-1:0]),
        .wr_data  ({s_tdata[23:16], s_tdata[15:8], s_tdata[31:24]}),
        .clr      (clr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_pixel (next_pix),
        .pix0     (pix0)
    );

    als_serializer #(
        .LED_COUNT (LED_COUNT),
        .AW        (AW)
    ) u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (accept),
        .cmd      (cmd),
        .timing   (timing_reg),
        .pix0     (pix0),
        .next_pix (next_pix),
        .idle     (idle),
        .res      (res),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.zero_high <= als_pkg::ZERO_HIGH_RESET;
            timing_reg.zero_low  <= als_pkg::ZERO_LOW_RESET;
            timing_reg.one_high  <= als_pkg::ONE_HIGH_RESET;
            timing_reg.one_low   <= als_pkg::ONE_LOW_RESET;
            timing_reg.latch_gap <= als_pkg::LATCH_GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                als_pkg::REG_ZERO_HIGH: timing_reg.zero_high <= cfg_data[7:0];
                als_pkg::REG_ZERO_LOW:  timing_reg.zero_low  <= cfg_data[7:0];
                als_pkg::REG_ONE_HIGH:  timing_reg.one_high  <= cfg_data[7:0];
                als_pkg::REG_ONE_LOW:   timing_reg.one_low   <= cfg_data[7:0];
                als_pkg::REG_LATCH_GAP: timing_reg.latch_gap <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_res_reg};

    // A rejected command never happens while the block is idle.
    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.rejected |-> !idle)
        else $error("command rejected while idle");

    // A show taken while idle drives the line high in its own result.
    a_show_starts_high: assert property (@(posedge clk) disable iff (!rst_n)
        accept && idle && (cmd == als_pkg::CMD_SHOW) |=> m_tvalid && m_tdata[0] && m_tdata[1])
        else $error("show did not start a high phase");

    // A high line is only ever reported during a frame.
    a_line_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.data_line |-> res.busy_res)
        else $error("line high while not busy");

    // The pixel store is never written or cleared during a frame.
    a_no_store_change_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !idle |-> !wr_en && !clr)
        else $error("pixel store changed during a frame");

endmodule
